@@ rtl/edd_pkg.sv @@
package edd_pkg;

   // configuration register
   localparam int LINE_WIDTH_W = 9;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 9'd256;

   // luma weights, 16 fraction bits
   localparam int PROD_R_W = 23;
   localparam int PROD_G_W = 24;
   localparam int PROD_B_W = 21;
   localparam int LUMA_SUM_W = 24;
   localparam logic [PROD_R_W-1:0] LUMA_R = 23'd19595;
   localparam logic [PROD_G_W-1:0] LUMA_G = 24'd38470;
   localparam logic [PROD_B_W-1:0] LUMA_B = 21'd7471;

   // error fraction bits
   localparam int FRAC_BITS = 4;

   // position of a pixel in its row and which shares stay inside the row
   typedef struct packed {
      logic row_start;
      logic row_last;
      logic zero_read;
      logic keep_left;
      logic keep_down;
      logic keep_right;
   } edd_class_type;

   // item handed from the front to the back
   typedef struct packed {
      edd_class_type        cls;
      logic [PROD_R_W-1:0] prod_r;
      logic [PROD_G_W-1:0] prod_g;
      logic [PROD_B_W-1:0] prod_b;
   } edd_pixel_type;

   // result item
   typedef struct packed {
      logic [7:0] gray_level;
      logic       dither_bit;
      logic [7:0] corrected_level;
   } edd_result_type;

endpackage

@@ rtl/edd_queue.sv @@
module edd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign count     = count_ff;
   assign head_data = data_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/edd_front.sv @@
module edd_front #(
   parameter int MAX_WIDTH = 256,
   parameter int COL_W     = 8,
   parameter int CNT_W     = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [7:0]                        red,
   input  logic [7:0]                        green,
   input  logic [7:0]                        blue,
   input  logic                              frame_start,
   input  logic [edd_pkg::LINE_WIDTH_W-1:0]  line_width,
   output logic [COL_W-1:0]                  col,
   output edd_pkg::edd_pixel_type            pix
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] prev_cnt_ff, prev_cnt_in;
   logic [CNT_W-1:0] prev_cnt;
   logic [CNT_W-1:0] w_eff;
   logic [CNT_W-1:0] col_x;
   logic [CNT_W-1:0] col_nx;

   // effective row width, clamped to 1..MAX_WIDTH
   always_comb begin
      if (line_width == '0) begin
         w_eff = CNT_W'(1);
      end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(line_width);
      end
   end

   // column of this pixel and the edge checks for its shares
   always_comb begin
      col      = frame_start ? '0 : col_ff;
      prev_cnt = frame_start ? '0 : prev_cnt_ff;
      col_x    = CNT_W'(col);
      col_nx   = col_x + CNT_W'(1);

      pix.cls.row_start  = (col == '0);
      pix.cls.row_last   = (col_nx >= w_eff);
      pix.cls.keep_right = (col_nx < w_eff);
      pix.cls.keep_down  = (col_x < w_eff);
      pix.cls.keep_left  = (col != '0) && (col_x <= w_eff);
      pix.cls.zero_read  = (col_x >= prev_cnt);

      pix.prod_r = edd_pkg::PROD_R_W'(red) * edd_pkg::LUMA_R;
      pix.prod_g = edd_pkg::PROD_G_W'(green) * edd_pkg::LUMA_G;
      pix.prod_b = edd_pkg::PROD_B_W'(blue) * edd_pkg::LUMA_B;
   end

   // column counter and length of the row above
   always_comb begin
      col_in      = col_ff;
      prev_cnt_in = prev_cnt_ff;
      if (accept) begin
         if (pix.cls.row_last) begin
            col_in      = '0;
            prev_cnt_in = col_nx;
         end else begin
            col_in      = COL_W'(col_nx);
            prev_cnt_in = prev_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         prev_cnt_ff <= '0;
      end else begin
         col_ff      <= col_in;
         prev_cnt_ff <= prev_cnt_in;
      end
   end

endmodule

@@ rtl/edd_back.sv @@
module edd_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int ERROR_BITS = 14,
   parameter int OUT_DEPTH  = 4,
   parameter int OCNT_W     = 3,
   parameter int COL_W      = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mid_empty,
   input  logic [COL_W-1:0]        head_col,
   input  edd_pkg::edd_pixel_type  head_pix,
   output logic                    mid_pop,
   input  logic [OCNT_W-1:0]       out_count,
   output logic                    out_push,
   output edd_pkg::edd_result_type out_data
);

   localparam int EW = ERROR_BITS;
   localparam int SW = ERROR_BITS + 3;
   localparam logic signed [SW-1:0] ERR_HI    = SW'((1 <<< (EW - 1)) - 1);
   localparam logic signed [SW-1:0] ERR_LO    = SW'(-(1 <<< (EW - 1)));
   localparam logic signed [SW-1:0] THRESHOLD = SW'(127);
   localparam logic signed [SW-1:0] WHITE     = SW'(255);
   localparam logic signed [SW-1:0] ONE_S     = SW'(1);
   localparam logic signed [SW-1:0] ZERO_S    = '0;

   // error line buffer: entry c holds the row above's share for column c
   logic signed [EW-1:0] err_mem [MAX_WIDTH];
   logic signed [EW-1:0] rd_ff;

   logic                   b1_v_ff, b1_v_in;
   logic [COL_W-1:0]       b1_col_ff, b1_col_in;
   edd_pkg::edd_class_type b1_cls_ff, b1_cls_in;
   logic [7:0]             b1_gray_ff, b1_gray_in;
   logic                   byp_v_ff, byp_v_in;
   logic signed [EW-1:0]   byp_val_ff, byp_val_in;
   logic signed [EW-1:0]   e_ff, e_in;
   logic signed [EW-1:0]   acc_a_ff, acc_a_in;
   logic signed [EW-1:0]   acc_b_ff, acc_b_in;
   logic                   pend_v_ff, pend_v_in;
   logic [COL_W-1:0]       pend_col_ff, pend_col_in;
   logic signed [EW-1:0]   pend_val_ff, pend_val_in;

   logic [edd_pkg::LUMA_SUM_W-1:0] luma;
   logic                 credit;
   logic signed [EW-1:0] prev_e;
   logic signed [SW-1:0] e_prev_s;
   logic signed [SW-1:0] right_add;
   logic signed [EW-1:0] cur_e;
   logic signed [SW-1:0] gray16;
   logic signed [SW-1:0] sum_v;
   logic signed [SW-1:0] corr;
   logic signed [SW-1:0] qerr;
   logic signed [SW-1:0] share3;
   logic signed [SW-1:0] share5;
   logic signed [EW-1:0] a_eff;
   logic signed [EW-1:0] left_val;
   logic signed [EW-1:0] down_val;
   logic                 white_px;
   logic [7:0]           level;
   logic                 pend_new;
   logic                 wr_en;
   logic [COL_W-1:0]     wr_addr;
   logic signed [EW-1:0] wr_data;

   function automatic logic signed [EW-1:0] sat_err(input logic signed [SW-1:0] v);
      logic signed [EW-1:0] r;
      if (v > ERR_HI) begin
         r = EW'(ERR_HI);
      end else if (v < ERR_LO) begin
         r = EW'(ERR_LO);
      end else begin
         r = EW'(v);
      end
      return r;
   endfunction

   // take an item only when the result queue has room for everything in flight
   always_comb begin
      credit  = ({1'b0, out_count} + (OCNT_W + 1)'(b1_v_ff)) < (OCNT_W + 1)'(OUT_DEPTH);
      mid_pop = !mid_empty && credit;
      luma    = edd_pkg::LUMA_SUM_W'(head_pix.prod_r) + edd_pkg::LUMA_SUM_W'(head_pix.prod_g)
              + edd_pkg::LUMA_SUM_W'(head_pix.prod_b);
      b1_v_in    = mid_pop;
      b1_col_in  = head_col;
      b1_cls_in  = head_pix.cls;
      b1_gray_in = luma[edd_pkg::LUMA_SUM_W-1:edd_pkg::LUMA_SUM_W-8];
   end

   // quantise one pixel and spread its error
   always_comb begin
      prev_e    = b1_cls_ff.zero_read ? '0 : (byp_v_ff ? byp_val_ff : rd_ff);
      e_prev_s  = SW'(e_ff);
      right_add = b1_cls_ff.row_start ? '0 : (e_prev_s <<< 3) - e_prev_s;
      cur_e     = sat_err(SW'(prev_e) + right_add);
      gray16    = {{(SW - 12){1'b0}}, b1_gray_ff, 4'b0000};
      sum_v     = gray16 + SW'(cur_e);
      corr      = (sum_v >>> edd_pkg::FRAC_BITS)
                + ((sum_v[SW-1] && (sum_v[3:0] != 4'b0000)) ? ONE_S : ZERO_S);
      white_px  = (corr > THRESHOLD);
      qerr      = white_px ? corr - WHITE : corr;
      share3    = (qerr <<< 1) + qerr;
      share5    = (qerr <<< 2) + qerr;

      if (corr > WHITE) begin
         level = 8'hFF;
      end else if (corr[SW-1]) begin
         level = 8'h00;
      end else begin
         level = corr[7:0];
      end

      a_eff    = b1_cls_ff.row_start ? '0 : acc_a_ff;
      left_val = sat_err(SW'(acc_b_ff) + (b1_cls_ff.keep_left ? share3 : '0));
      down_val = sat_err(SW'(a_eff) + (b1_cls_ff.keep_down ? share5 : '0));

      e_in     = b1_v_ff ? EW'(qerr) : e_ff;
      acc_a_in = b1_v_ff ? (b1_cls_ff.keep_right ? EW'(qerr) : '0) : acc_a_ff;
      acc_b_in = b1_v_ff ? down_val : acc_b_ff;

      out_push                 = b1_v_ff;
      out_data.gray_level      = b1_gray_ff;
      out_data.dither_bit      = white_px;
      out_data.corrected_level = level;
   end

   // line buffer write: finished column to the left, or the last column from the pending register
   always_comb begin
      pend_new    = b1_v_ff && b1_cls_ff.row_last;
      pend_v_in   = pend_new;
      pend_col_in = pend_new ? b1_col_ff : pend_col_ff;
      pend_val_in = pend_new ? down_val : pend_val_ff;
      if (b1_v_ff && !b1_cls_ff.row_start) begin
         wr_en   = 1'b1;
         wr_addr = b1_col_ff - 1'b1;
         wr_data = left_val;
      end else begin
         wr_en   = pend_v_ff;
         wr_addr = pend_col_ff;
         wr_data = pend_val_ff;
      end
   end

   // forward values that reach the buffer in the same cycle as the read
   always_comb begin
      byp_v_in   = 1'b0;
      byp_val_in = wr_data;
      if (pend_new && (b1_col_ff == head_col)) begin
         byp_v_in   = 1'b1;
         byp_val_in = down_val;
      end else if (wr_en && (wr_addr == head_col)) begin
         byp_v_in   = 1'b1;
         byp_val_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         b1_v_ff   <= b1_v_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_col_ff   <= b1_col_in;
      b1_cls_ff   <= b1_cls_in;
      b1_gray_ff  <= b1_gray_in;
      byp_v_ff    <= byp_v_in;
      byp_val_ff  <= byp_val_in;
      e_ff        <= e_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      pend_col_ff <= pend_col_in;
      pend_val_ff <= pend_val_in;
   end

   // line buffer memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         err_mem[wr_addr] <= wr_data;
      end
      rd_ff <= err_mem[head_col];
   end

endmodule

@@ rtl/error_diffusion_dither.sv @@
// Floyd-Steinberg error-diffusion dither for an RGB raster stream. One pixel item is taken
// per clock unless the pixel queue is full, and one result item comes out per pixel, in
// order; a result passes the pixel queue, the b1 register and the result queue to the rsp_
// ports. The rate is set by the error feedback to the right neighbour and by the line
// buffer, a single memory of MAX_WIDTH words of ERROR_BITS bits with one write and one read
// port per clock. The pixel queue and the result queue are four items deep each. Frame
// start and row ends need no clearing pass: the length of the row above is tracked, so
// columns it never wrote read as zero. csr_write_data sets the row width (0 acts as 1,
// values above MAX_WIDTH act as MAX_WIDTH); change it only while no item is in flight.
module error_diffusion_dither #(
   parameter int MAX_WIDTH  = 256,
   parameter int ERROR_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_red,
   input  logic [7:0]                       req_green,
   input  logic [7:0]                       req_blue,
   input  logic                             req_frame_start,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_gray_level,
   output logic                             rsp_dither_bit,
   output logic [7:0]                       rsp_corrected_level,
   input  logic                             csr_write_enable,
   input  logic [edd_pkg::LINE_WIDTH_W-1:0] csr_write_data
);

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int PIX_W       = $bits(edd_pkg::edd_pixel_type);
   localparam int MID_W       = COL_W + PIX_W;
   localparam int RES_W       = $bits(edd_pkg::edd_result_type);

   logic [edd_pkg::LINE_WIDTH_W-1:0] line_width_ff, line_width_in;

   logic                    req_accept;
   logic [COL_W-1:0]        front_col;
   edd_pkg::edd_pixel_type  front_pix;
   logic [MID_W-1:0]        mid_head;
   logic                    mid_empty;
   logic                    mid_pop;
   logic [COL_W-1:0]        mid_head_col;
   edd_pkg::edd_pixel_type  mid_head_pix;
   logic                    out_push;
   edd_pkg::edd_result_type out_data;
   logic [QCNT_W-1:0]       out_count;
   logic                    out_full;
   logic [RES_W-1:0]        rsp_head;
   edd_pkg::edd_result_type rsp_res;

   // row width register
   always_comb begin
      line_width_in = csr_write_enable ? csr_write_data : line_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= edd_pkg::LINE_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   assign req_accept = req_push && !req_full;

   // front: column tracking, edge classification, luma products
   edd_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W),
      .CNT_W     (CNT_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .frame_start (req_frame_start),
      .line_width  (line_width_ff),
      .col         (front_col),
      .pix         (front_pix)
   );

   // pixel queue between front and back
   edd_queue #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data ({front_col, front_pix}),
      .pop       (mid_pop),
      .head_data (mid_head),
      .empty     (mid_empty),
      .full      (req_full),
      .count     ()
   );

   assign mid_head_col = mid_head[MID_W-1:PIX_W];
   assign mid_head_pix = edd_pkg::edd_pixel_type'(mid_head[PIX_W-1:0]);

   // back: luma, quantisation and error diffusion
   edd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .ERROR_BITS (ERROR_BITS),
      .OUT_DEPTH  (QUEUE_DEPTH),
      .OCNT_W     (QCNT_W),
      .COL_W      (COL_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .head_col  (mid_head_col),
      .head_pix  (mid_head_pix),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // result queue
   edd_queue #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .head_data (rsp_head),
      .empty     (rsp_empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_res             = edd_pkg::edd_result_type'(rsp_head);
   assign rsp_gray_level      = rsp_res.gray_level;
   assign rsp_dither_bit      = rsp_res.dither_bit;
   assign rsp_corrected_level = rsp_res.corrected_level;

`ifndef NO_ASSERTIONS
   // the back reserves room, so a finished item never meets a full result queue
   a_no_result_drop: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result item pushed into a full result queue");

   // the back only takes an item when one is waiting
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("pixel queue popped while empty");

   // a popped item always reaches the result queue on the next cycle
   a_pop_then_push: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> out_push)
      else $error("popped item did not reach the result queue");
`endif

endmodule
